[rtl/fcl_pkg.sv]
// ----------------------------------------------------------------------------
// Dense layer MAC package
// Sizes, operation and register codes, and shared types of the dense layer.
// ----------------------------------------------------------------------------
package fcl_pkg;

   localparam int MAX_INPUTS    = 128;
   localparam int MAX_OUTPUTS   = 64;
   localparam int DATA_WIDTH    = 16;
   localparam int FRAC_BITS     = 12;
   localparam int ACC_WIDTH     = 40;
   localparam int COL_BITS      = $clog2(MAX_INPUTS);
   localparam int ROW_BITS      = $clog2(MAX_OUTPUTS);
   localparam int ICOUNT_BITS   = 8;
   localparam int OCOUNT_BITS   = 7;
   localparam int MAC_LATENCY   = 2;
   localparam int ACC_STEPS     = MAX_OUTPUTS + MAC_LATENCY;
   localparam int CNT_BITS      = $clog2(ACC_STEPS);
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 8;

   typedef enum logic [1:0] {
      OP_WEIGHT = 2'd0,
      OP_BIAS   = 2'd1,
      OP_ACT    = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_INPUT_COUNT  = 2'd0,
      CSR_OUTPUT_COUNT = 2'd1
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACC,
      ST_BRD,
      ST_EMIT
   } state_type;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [ACC_WIDTH-1:0]  acc_type;

   typedef struct packed {
      logic clr;
      logic add_en;
   } mac_ctrl_type;

endpackage

[rtl/fcl_if.sv]
// ----------------------------------------------------------------------------
// Dense layer channel interfaces
// Request, result and register write channels with valid and ready.
// ----------------------------------------------------------------------------
interface fcl_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             op;
   logic [fcl_pkg::ROW_BITS-1:0]           row;
   logic [fcl_pkg::COL_BITS-1:0]           col;
   logic signed [fcl_pkg::DATA_WIDTH-1:0]  value;
   logic                                   last;
   modport source (output valid, op, row, col, value, last, input ready);
   modport sink (input valid, op, row, col, value, last, output ready);
endinterface

interface fcl_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [fcl_pkg::ROW_BITS-1:0]           neuron;
   logic signed [fcl_pkg::DATA_WIDTH-1:0]  result_value;
   logic                                   saturated;
   logic                                   last_result;
   modport source (output valid, neuron, result_value, saturated, last_result, input ready);
   modport sink (input valid, neuron, result_value, saturated, last_result, output ready);
endinterface

interface fcl_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [fcl_pkg::CSR_IDX_BITS-1:0]       index;
   logic [fcl_pkg::CSR_DATA_BITS-1:0]      data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/fcl_cell.sv]
// ----------------------------------------------------------------------------
// Dense layer accumulator cell
// One accumulator of the ring; takes its neighbor's value on each shift.
// ----------------------------------------------------------------------------
module fcl_cell (
   input  logic             clock,
   input  logic             shift_en,
   input  fcl_pkg::acc_type d,
   output fcl_pkg::acc_type q
);

   fcl_pkg::acc_type acc_ff;
   fcl_pkg::acc_type acc_in;

   always_comb begin
      acc_in = shift_en ? d : acc_ff;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign q = acc_ff;

endmodule

[rtl/fcl_mac.sv]
// ----------------------------------------------------------------------------
// Dense layer multiply-accumulate unit
// Registered weight times activation product added into the ring head.
// ----------------------------------------------------------------------------
module fcl_mac (
   input  logic                  clock,
   input  fcl_pkg::data_type     weight,
   input  fcl_pkg::data_type     act,
   input  fcl_pkg::acc_type      head,
   input  fcl_pkg::mac_ctrl_type ctrl,
   output fcl_pkg::acc_type      tail
);

   logic signed [2*fcl_pkg::DATA_WIDTH-1:0] prod_ff;
   logic signed [2*fcl_pkg::DATA_WIDTH-1:0] prod_in;
   fcl_pkg::acc_type                        base;
   fcl_pkg::acc_type                        addend;

   always_comb begin
      prod_in = weight * act;
      base    = ctrl.clr ? '0 : head;
      addend  = ctrl.add_en ? fcl_pkg::acc_type'(prod_ff) : '0;
      tail    = base + addend;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

[rtl/fully_connected_layer_mac.sv]
// An activation beat runs one accumulate pass over the ring (one weight memory read per output
// neuron through the shared multiplier, 2 stages deep); a last activation then adds a bias
// read and a result beat per used output neuron, and a result beat waits on ready.
// Requests are taken only while idle: one write beat per cycle, none during a pass.
// Reset clears the control state and counts; the weight and bias stores hold no reset value.
// ----------------------------------------------------------------------------
// Dense layer forward pass
// Accumulator ring fed by one multiply-accumulate unit, with bias and saturation.
// ----------------------------------------------------------------------------
module fully_connected_layer_mac (
   input  logic      clock,
   input  logic      reset,
   fcl_req_if.sink   req_bus,
   fcl_rsp_if.source rsp_bus,
   fcl_csr_if.sink   csr_bus
);

   localparam int N = fcl_pkg::MAX_OUTPUTS;

   fcl_pkg::state_type state_ff, state_in;
   logic [fcl_pkg::CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [fcl_pkg::ROW_BITS-1:0]    j_ff, j_in;
   logic [fcl_pkg::COL_BITS-1:0]    col_ff, col_in;
   fcl_pkg::data_type               act_ff, act_in;
   logic                            last_ff, last_in;
   logic                            clr_ff, clr_in;
   logic                            started_ff, started_in;
   logic [fcl_pkg::ICOUNT_BITS-1:0] icount_ff, icount_in;
   logic [fcl_pkg::OCOUNT_BITS-1:0] ocount_ff, ocount_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [fcl_pkg::ROW_BITS-1:0]    rsp_neuron_ff, rsp_neuron_in;
   fcl_pkg::data_type               rsp_value_ff, rsp_value_in;
   logic                            rsp_sat_ff, rsp_sat_in;
   logic                            rsp_last_ff, rsp_last_in;

   fcl_pkg::data_type wt_mem [fcl_pkg::MAX_INPUTS*N];
   fcl_pkg::data_type bias_mem [N];
   fcl_pkg::data_type wt_q_ff;
   fcl_pkg::data_type bias_q_ff;

   fcl_pkg::acc_type      ring [N];
   fcl_pkg::acc_type      tail;
   logic                  shift_en;
   fcl_pkg::mac_ctrl_type mac_ctrl;

   logic                  accept;
   logic                  wt_we, bias_we;
   logic [fcl_pkg::OCOUNT_BITS-1:0] nout;
   logic [fcl_pkg::CNT_BITS-1:0]    step;
   logic                  load;
   logic signed [fcl_pkg::ACC_WIDTH+1:0] sum;
   logic signed [fcl_pkg::ACC_WIDTH+1-fcl_pkg::FRAC_BITS:0] rnd;
   logic                  hi_clip, lo_clip;

   assign req_bus.ready = (state_ff == fcl_pkg::ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign accept        = req_bus.valid && req_bus.ready;
   assign nout          = (ocount_ff > fcl_pkg::OCOUNT_BITS'(N)) ?
                          fcl_pkg::OCOUNT_BITS'(N) : ocount_ff;
   assign step          = cnt_ff - fcl_pkg::CNT_BITS'(fcl_pkg::MAC_LATENCY);

   assign wt_we   = accept && (req_bus.op == fcl_pkg::OP_WEIGHT) &&
                    (fcl_pkg::OCOUNT_BITS'(req_bus.row) < ocount_ff) &&
                    (fcl_pkg::ICOUNT_BITS'(req_bus.col) < icount_ff);
   assign bias_we = accept && (req_bus.op == fcl_pkg::OP_BIAS) &&
                    (fcl_pkg::OCOUNT_BITS'(req_bus.row) < ocount_ff);

   always_ff @(posedge clock) begin
      if (wt_we) begin
         wt_mem[{req_bus.row, req_bus.col}] <= req_bus.value;
      end
      wt_q_ff <= wt_mem[{cnt_ff[fcl_pkg::ROW_BITS-1:0], col_ff}];
   end

   always_ff @(posedge clock) begin
      if (bias_we) begin
         bias_mem[req_bus.row] <= req_bus.value;
      end
      bias_q_ff <= bias_mem[j_ff];
   end

   for (genvar i = 0; i < N; i++) begin : g_cell
      fcl_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .d        ((i == N-1) ? tail : ring[(i+1) % N]),
         .q        (ring[i])
      );
   end

   fcl_mac u_mac (
      .clock  (clock),
      .weight (wt_q_ff),
      .act    (act_ff),
      .head   (ring[0]),
      .ctrl   (mac_ctrl),
      .tail   (tail)
   );

   always_comb begin
      sum = $signed({{2{ring[0][fcl_pkg::ACC_WIDTH-1]}}, ring[0]})
            + ($signed({{(fcl_pkg::ACC_WIDTH+2-fcl_pkg::DATA_WIDTH){bias_q_ff[fcl_pkg::DATA_WIDTH-1]}},
                        bias_q_ff}) <<< fcl_pkg::FRAC_BITS)
            + $signed((fcl_pkg::ACC_WIDTH+2)'(1 << (fcl_pkg::FRAC_BITS-1)));
      rnd     = sum[fcl_pkg::ACC_WIDTH+1:fcl_pkg::FRAC_BITS];
      hi_clip = rnd > $signed((fcl_pkg::ACC_WIDTH+2-fcl_pkg::FRAC_BITS)'(32767));
      lo_clip = rnd < -$signed((fcl_pkg::ACC_WIDTH+2-fcl_pkg::FRAC_BITS)'(32768));
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      j_in          = j_ff;
      col_in        = col_ff;
      act_in        = act_ff;
      last_in       = last_ff;
      clr_in        = clr_ff;
      started_in    = started_ff;
      icount_in     = icount_ff;
      ocount_in     = ocount_ff;
      rsp_neuron_in = rsp_neuron_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_sat_in    = rsp_sat_ff;
      rsp_last_in   = rsp_last_ff;
      shift_en      = 1'b0;
      mac_ctrl      = '0;
      load          = 1'b0;

      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            fcl_pkg::CSR_INPUT_COUNT:  icount_in = csr_bus.data;
            fcl_pkg::CSR_OUTPUT_COUNT: ocount_in = csr_bus.data[fcl_pkg::OCOUNT_BITS-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         fcl_pkg::ST_IDLE: begin
            if (accept && req_bus.op == fcl_pkg::OP_ACT) begin
               col_in     = req_bus.col;
               act_in     = req_bus.value;
               last_in    = req_bus.last;
               clr_in     = !started_ff;
               started_in = !req_bus.last;
               cnt_in     = '0;
               state_in   = fcl_pkg::ST_ACC;
            end
         end
         fcl_pkg::ST_ACC: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff >= fcl_pkg::CNT_BITS'(fcl_pkg::MAC_LATENCY)) begin
               shift_en        = 1'b1;
               mac_ctrl.clr    = clr_ff;
               mac_ctrl.add_en = (fcl_pkg::OCOUNT_BITS'(step) < nout) &&
                                 (fcl_pkg::ICOUNT_BITS'(col_ff) < icount_ff);
            end
            if (cnt_ff == fcl_pkg::CNT_BITS'(fcl_pkg::ACC_STEPS-1)) begin
               j_in     = '0;
               state_in = (last_ff && nout != '0) ? fcl_pkg::ST_BRD : fcl_pkg::ST_IDLE;
            end
         end
         fcl_pkg::ST_BRD: begin
            state_in = fcl_pkg::ST_EMIT;
         end
         fcl_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               load          = 1'b1;
               shift_en      = 1'b1;
               rsp_neuron_in = j_ff;
               rsp_sat_in    = hi_clip || lo_clip;
               rsp_value_in  = hi_clip ? 16'sh7fff : lo_clip ? 16'sh8000 :
                               rnd[fcl_pkg::DATA_WIDTH-1:0];
               rsp_last_in   = (fcl_pkg::OCOUNT_BITS'(j_ff) + 1'b1) == nout;
               j_in          = j_ff + 1'b1;
               state_in      = rsp_last_in ? fcl_pkg::ST_IDLE : fcl_pkg::ST_BRD;
            end
         end
         default: state_in = fcl_pkg::ST_IDLE;
      endcase

      rsp_valid_in = load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcl_pkg::ST_IDLE;
         cnt_ff       <= '0;
         j_ff         <= '0;
         started_ff   <= 1'b0;
         clr_ff       <= 1'b0;
         last_ff      <= 1'b0;
         icount_ff    <= fcl_pkg::ICOUNT_BITS'(128);
         ocount_ff    <= fcl_pkg::OCOUNT_BITS'(64);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         j_ff         <= j_in;
         started_ff   <= started_in;
         clr_ff       <= clr_in;
         last_ff      <= last_in;
         icount_ff    <= icount_in;
         ocount_ff    <= ocount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff        <= col_in;
      act_ff        <= act_in;
      rsp_neuron_ff <= rsp_neuron_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_sat_ff    <= rsp_sat_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.neuron       = rsp_neuron_ff;
   assign rsp_bus.result_value = rsp_value_ff;
   assign rsp_bus.saturated    = rsp_sat_ff;
   assign rsp_bus.last_result  = rsp_last_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == fcl_pkg::ST_ACC |-> cnt_ff <= fcl_pkg::CNT_BITS'(fcl_pkg::ACC_STEPS-1))
      else $error("accumulate step count out of range");

   a_acc_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == fcl_pkg::ST_ACC && cnt_ff == fcl_pkg::CNT_BITS'(fcl_pkg::ACC_STEPS-1)
      |=> state_ff != fcl_pkg::ST_ACC)
      else $error("accumulate pass did not end");

   a_emit_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == fcl_pkg::ST_ACC && cnt_ff == fcl_pkg::CNT_BITS'(fcl_pkg::ACC_STEPS-1)
      && last_ff && nout != '0 |=> state_ff == fcl_pkg::ST_BRD && j_ff == '0)
      else $error("result pass did not start at neuron zero");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      load && (fcl_pkg::OCOUNT_BITS'(j_ff) + 1'b1) == nout
      |=> rsp_last_ff && state_ff == fcl_pkg::ST_IDLE)
      else $error("final result beat not flagged");

endmodule

[tb/fully_connected_layer_mac_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dense layer MAC testbench
// Drives weight, bias and activation beats into the dense layer under several
// count settings and idle patterns. A scoreboard class predicts every result
// beat in fixed point and compares it field by field.
// ----------------------------------------------------------------------------

typedef struct {
   logic [fcl_pkg::ROW_BITS-1:0]          neuron;
   logic signed [fcl_pkg::DATA_WIDTH-1:0] result_value;
   logic                                  saturated;
   logic                                  last_result;
} neuron_result_type;

class dense_sum_scoreboard;
   logic signed [fcl_pkg::DATA_WIDTH-1:0] weight_mem [fcl_pkg::MAX_OUTPUTS][fcl_pkg::MAX_INPUTS];
   bit                           weight_set [fcl_pkg::MAX_OUTPUTS][fcl_pkg::MAX_INPUTS];
   logic signed [fcl_pkg::DATA_WIDTH-1:0] bias_mem [fcl_pkg::MAX_OUTPUTS];
   bit                           bias_set [fcl_pkg::MAX_OUTPUTS];
   logic [fcl_pkg::ACC_WIDTH-1:0] acc_mem [fcl_pkg::MAX_OUTPUTS];
   bit                           started;
   int                           in_count;
   int                           out_count;
   neuron_result_type            expected_q[$];
   int                           errors;

   function void init();
      foreach (acc_mem[j]) acc_mem[j] = '0;
      started   = 0;
      in_count  = fcl_pkg::MAX_INPUTS;
      out_count = fcl_pkg::MAX_OUTPUTS;
      errors    = 0;
   endfunction

   function int used_inputs();
      return (in_count < fcl_pkg::MAX_INPUTS) ? in_count : fcl_pkg::MAX_INPUTS;
   endfunction

   function int used_outputs();
      return (out_count < fcl_pkg::MAX_OUTPUTS) ? out_count : fcl_pkg::MAX_OUTPUTS;
   endfunction

   function void set_register(fcl_pkg::csr_idx_type idx,
                              logic [fcl_pkg::CSR_DATA_BITS-1:0] data);
      if (idx == fcl_pkg::CSR_INPUT_COUNT) in_count = data;
      else if (idx == fcl_pkg::CSR_OUTPUT_COUNT) out_count = data & 8'h7F;
   endfunction

   function void note_beat(logic [1:0] op, logic [fcl_pkg::ROW_BITS-1:0] row,
                           logic [fcl_pkg::COL_BITS-1:0] col,
                           logic signed [fcl_pkg::DATA_WIDTH-1:0] value, logic last);
      int nin;
      int nout;
      logic signed [2*fcl_pkg::DATA_WIDTH-1:0] prod;
      longint s;
      longint r;
      neuron_result_type res;
      nin  = used_inputs();
      nout = used_outputs();
      if (op == fcl_pkg::OP_WEIGHT) begin
         if (row < nout && col < nin) begin
            weight_mem[row][col] = value;
            weight_set[row][col] = 1;
         end
      end else if (op == fcl_pkg::OP_BIAS) begin
         if (row < nout) begin
            bias_mem[row] = value;
            bias_set[row] = 1;
         end
      end else if (op == fcl_pkg::OP_ACT) begin
         if (!started) begin
            foreach (acc_mem[j]) acc_mem[j] = '0;
            started = 1;
         end
         if (col < nin) begin
            for (int j = 0; j < nout; j++) begin
               prod = weight_mem[j][col] * value;
               acc_mem[j] = acc_mem[j]
                  + {{(fcl_pkg::ACC_WIDTH-2*fcl_pkg::DATA_WIDTH){prod[2*fcl_pkg::DATA_WIDTH-1]}},
                     prod};
            end
         end
         if (last) begin
            for (int j = 0; j < nout; j++) begin
               s = longint'($signed(acc_mem[j]))
                   + (longint'(bias_mem[j]) <<< fcl_pkg::FRAC_BITS)
                   + (longint'(1) <<< (fcl_pkg::FRAC_BITS - 1));
               r = s >>> fcl_pkg::FRAC_BITS;
               res.saturated = 0;
               if (r > 32767) begin
                  r = 32767;
                  res.saturated = 1;
               end
               if (r < -32768) begin
                  r = -32768;
                  res.saturated = 1;
               end
               res.neuron       = fcl_pkg::ROW_BITS'(j);
               res.result_value = r[fcl_pkg::DATA_WIDTH-1:0];
               res.last_result  = (j + 1 == nout);
               expected_q.push_back(res);
            end
            started = 0;
         end
      end
   endfunction

   function void check_beat(neuron_result_type got);
      neuron_result_type exp_res;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result beat neuron=%0d value=%0d sat=%0b last=%0b",
                  $realtime, got.neuron, got.result_value, got.saturated, got.last_result);
         errors++;
         return;
      end
      exp_res = expected_q.pop_front();
      if (got.neuron !== exp_res.neuron) begin
         $display("%0t: neuron expected %0d actual %0d", $realtime, exp_res.neuron, got.neuron);
         errors++;
      end
      if (got.result_value !== exp_res.result_value) begin
         $display("%0t: result_value expected %0d actual %0d (neuron %0d)", $realtime,
                  exp_res.result_value, got.result_value, exp_res.neuron);
         errors++;
      end
      if (got.saturated !== exp_res.saturated) begin
         $display("%0t: saturated expected %0b actual %0b (neuron %0d)", $realtime,
                  exp_res.saturated, got.saturated, exp_res.neuron);
         errors++;
      end
      if (got.last_result !== exp_res.last_result) begin
         $display("%0t: last_result expected %0b actual %0b (neuron %0d)", $realtime,
                  exp_res.last_result, got.last_result, exp_res.neuron);
         errors++;
      end
   endfunction
endclass

module fully_connected_layer_mac_tb;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic clock;
   logic reset;

   fcl_req_if req_bus ();
   fcl_rsp_if rsp_bus ();
   fcl_csr_if csr_bus ();

   fully_connected_layer_mac u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   dense_sum_scoreboard sb;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_cycles;
   int col_hi;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

   // Result side: ready is driven at the falling edge, beats are taken at the rising edge.
   initial begin
      rsp_bus.ready = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_bus.ready <= 0;
            hold_cycles--;
         end else begin
            rsp_bus.ready <= ($urandom % 100) >= recv_stall_pct;
         end
      end
   end

   initial begin
      neuron_result_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.neuron       = rsp_bus.neuron;
            got.result_value = rsp_bus.result_value;
            got.saturated    = rsp_bus.saturated;
            got.last_result  = rsp_bus.last_result;
            sb.check_beat(got);
         end
      end
   end

   function automatic logic signed [fcl_pkg::DATA_WIDTH-1:0] pick_value();
      case ($urandom % 4)
         0: return fcl_pkg::DATA_WIDTH'($urandom);
         1: return fcl_pkg::DATA_WIDTH'($urandom_range(0, 8191) - 4096);
         2: case ($urandom % 4)
               0: return 16'sh7FFF;
               1: return 16'sh8000;
               2: return 16'sh0000;
               default: return 16'sh1000;
            endcase
         default: return fcl_pkg::DATA_WIDTH'($urandom_range(0, 1023) - 512);
      endcase
   endfunction

   task automatic send_beat(logic [1:0] op, logic [fcl_pkg::ROW_BITS-1:0] row,
                            logic [fcl_pkg::COL_BITS-1:0] col,
                            logic signed [fcl_pkg::DATA_WIDTH-1:0] value, logic last);
      @(negedge clock);
      if (($urandom % 100) < send_idle_pct) begin
         req_bus.valid <= 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_bus.valid <= 1;
      req_bus.op    <= op;
      req_bus.row   <= row;
      req_bus.col   <= col;
      req_bus.value <= value;
      req_bus.last  <= last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_beat(op, row, col, value, last);
   endtask

   // Loads any weight or bias that this activation would read before it is written.
   task automatic send_activation(logic [fcl_pkg::COL_BITS-1:0] col,
                                  logic signed [fcl_pkg::DATA_WIDTH-1:0] value, logic last);
      if (col < sb.used_inputs()) begin
         for (int j = 0; j < sb.used_outputs(); j++) begin
            if (!sb.weight_set[j][col])
               send_beat(fcl_pkg::OP_WEIGHT, fcl_pkg::ROW_BITS'(j), col, pick_value(), 1'b0);
         end
      end
      if (last) begin
         for (int j = 0; j < sb.used_outputs(); j++) begin
            if (!sb.bias_set[j])
               send_beat(fcl_pkg::OP_BIAS, fcl_pkg::ROW_BITS'(j),
                         fcl_pkg::COL_BITS'($urandom), pick_value(), 1'b0);
         end
      end
      send_beat(fcl_pkg::OP_ACT, fcl_pkg::ROW_BITS'($urandom), col, value, last);
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(fcl_pkg::csr_idx_type idx,
                            logic [fcl_pkg::CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      sb.set_register(idx, data);
      @(negedge clock);
      csr_bus.valid <= 0;
   endtask

   task automatic random_phase(int in_cnt, int out_cnt, int hi, int n_items,
                               int idle_pct, int stall_pct, int hold);
      int kind;
      drain();
      write_reg(fcl_pkg::CSR_INPUT_COUNT, fcl_pkg::CSR_DATA_BITS'(in_cnt));
      write_reg(fcl_pkg::CSR_OUTPUT_COUNT, fcl_pkg::CSR_DATA_BITS'(out_cnt));
      col_hi         = hi;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      hold_cycles    = hold;
      for (int i = 0; i < n_items; i++) begin
         kind = $urandom % 100;
         if (kind < 70)
            send_activation((($urandom % 8) == 0) ? fcl_pkg::COL_BITS'($urandom)
                            : fcl_pkg::COL_BITS'($urandom_range(0, col_hi)),
                            pick_value(), ($urandom % 6) == 0);
         else if (kind < 85)
            send_beat(fcl_pkg::OP_WEIGHT, fcl_pkg::ROW_BITS'($urandom),
                      (($urandom % 4) == 0) ? fcl_pkg::COL_BITS'($urandom)
                      : fcl_pkg::COL_BITS'($urandom_range(0, col_hi)),
                      pick_value(), 1'($urandom));
         else if (kind < 93)
            send_beat(fcl_pkg::OP_BIAS, fcl_pkg::ROW_BITS'($urandom),
                      fcl_pkg::COL_BITS'($urandom), pick_value(), 1'($urandom));
         else
            send_beat(OP_UNUSED, fcl_pkg::ROW_BITS'($urandom), fcl_pkg::COL_BITS'($urandom),
                      fcl_pkg::DATA_WIDTH'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      sb = new();
      sb.init();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_cycles    = 0;
      col_hi         = 3;
      reset          = 1;
      req_bus.valid  = 0;
      req_bus.op     = fcl_pkg::OP_WEIGHT;
      req_bus.row    = '0;
      req_bus.col    = '0;
      req_bus.value  = '0;
      req_bus.last   = 0;
      csr_bus.valid  = 0;
      csr_bus.index  = fcl_pkg::CSR_INPUT_COUNT;
      csr_bus.data   = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed beats at the reset counts: field extremes, every operation, saturation.
      send_beat(fcl_pkg::OP_WEIGHT, 6'd63, 7'd127, 16'sh8000, 1'b1);
      send_beat(fcl_pkg::OP_WEIGHT, 6'd0, 7'd0, 16'sh7FFF, 1'b0);
      send_beat(fcl_pkg::OP_BIAS, 6'd63, 7'd127, 16'sh7FFF, 1'b0);
      send_beat(fcl_pkg::OP_BIAS, 6'd0, 7'd0, 16'sh8000, 1'b0);
      send_beat(OP_UNUSED, 6'd63, 7'd127, 16'sh7FFF, 1'b1);
      send_activation(7'd0, 16'sh7FFF, 1'b0);
      send_activation(7'd127, 16'sh8000, 1'b1);
      send_activation(7'd127, 16'sh0001, 1'b1);
      send_activation(7'd0, 16'sh8000, 1'b0);
      send_activation(7'd0, 16'sh8000, 1'b1);
      drain();

      // Small counts: out-of-range writes and activations; zero and oversized counts follow.
      write_reg(fcl_pkg::CSR_INPUT_COUNT, 8'd2);
      write_reg(fcl_pkg::CSR_OUTPUT_COUNT, 8'd3);
      send_beat(fcl_pkg::OP_WEIGHT, 6'd5, 7'd0, 16'sh1234, 1'b0);
      send_beat(fcl_pkg::OP_WEIGHT, 6'd0, 7'd9, 16'sh1234, 1'b0);
      send_activation(7'd1, 16'sh0800, 1'b0);
      send_activation(7'd100, 16'sh7FFF, 1'b1);
      send_activation(7'd100, 16'sh7FFF, 1'b1);

      random_phase(8, 5, 10, 45, 0, 0, 0);
      random_phase(1, 1, 2, 40, 63, 0, 0);
      random_phase(255, 2, 5, 40, 0, 63, 0);
      random_phase(40, 12, 44, 50, 0, 0, 600);
      random_phase(0, 3, 4, 25, 24, 24, 0);
      random_phase(5, 0, 7, 25, 24, 24, 0);
      random_phase(128, 4, 130, 50, 24, 24, 0);
      random_phase(3, 64, 4, 40, 63, 0, 0);
      random_phase(16, 8, 18, 45, 0, 63, 0);

      drain();
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

[files.f]
rtl/fcl_pkg.sv
rtl/fcl_if.sv
rtl/fcl_cell.sv
rtl/fcl_mac.sv
rtl/fully_connected_layer_mac.sv
tb/fully_connected_layer_mac_tb.sv
